// File: hdl/hbt_pkg.sv
// Shared codes and field widths for the host bucket table.
package hbt_pkg;

    localparam int KEY_W    = 32;
    localparam int WAYS     = 8;
    localparam int WAY_W    = 3;
    localparam int OPC_W    = 2;
    localparam int STAT_W   = 2;
    localparam int PRQ_W    = 4;
    localparam int NOW_W    = 12;
    localparam int OBKT_W   = 10;
    localparam int OHDL_W   = 20;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    localparam logic [KEY_W-1:0] HASH_MUL = 32'h3258_3499;

    typedef enum logic [OPC_W-1:0] {
        OP_LOOKUP      = 2'd0,
        OP_INSERT      = 2'd1,
        OP_INSERT_AUTH = 2'd2,
        OP_UNUSED      = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_MISSING  = 2'd2,
        ST_REFUSED  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MULT  = 5'b00100,
        S_ADDR  = 5'b01000,
        S_EVAL  = 5'b10000
    } state_t;

endpackage

// File: hdl/hbt_ram.sv
// Generic simple dual-port RAM with a registered read port.
module hbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/host_bucket_table_core.sv
// Host bucket table: an 8-way set-associative IPv4 host table over one row RAM.
//
// A request arrives on the s_ channel: tuser carries the opcode (lookup,
// insert, authorized insert), tdata the address, request priority and
// current time. Exactly one result leaves on the m_ channel per request:
// tuser carries the status, tdata the way, bucket and handle.
//
// Each bucket is one RAM row holding all eight ways. The result is
// registered after the hash multiply, the row read and the evaluation of
// the row with its write back. A new request is accepted only once the
// previous one has left evaluation; the read-modify-write of the bucket
// row sets that limit.
//
// After reset the block sweeps the RAM, clearing one row per cycle;
// s_tready stays low during the sweep. If the receiver stalls, the result
// is held in the output register and the next request is still taken in
// and worked up to evaluation, where it waits until the output register
// is free.
module host_bucket_table_core #(
    parameter int BUCKETS     = 1024,
    parameter int AGE_BITS    = 12,
    parameter int PRIO_BITS   = 4,
    parameter int HANDLE_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // address[31:0], priority_req[35:32], now_sec[47:36]
    input  logic [hbt_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [hbt_pkg::OPC_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // way[2:0], bucket[12:3], handle[32:13], zeros[39:33]
    output logic [hbt_pkg::M_DATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [hbt_pkg::STAT_W-1:0]    m_tuser
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int EW    = hbt_pkg::KEY_W + AGE_BITS + PRIO_BITS + HANDLE_BITS;
    localparam int ROW_W = hbt_pkg::WAYS * EW;
    localparam int AGE_LO  = hbt_pkg::KEY_W;
    localparam int PRIO_LO = AGE_LO + AGE_BITS;
    localparam int HDL_LO  = PRIO_LO + PRIO_BITS;
    localparam int RANK_W  = PRIO_BITS + AGE_BITS;

    hbt_pkg::state_t state_reg, state_next;

    logic [BW-1:0]                  clr_reg, clr_next;
    logic [hbt_pkg::OPC_W-1:0]      op_reg;
    logic [hbt_pkg::KEY_W-1:0]      addr_reg;
    logic [PRIO_BITS-1:0]           preq_reg;
    logic [AGE_BITS-1:0]            now_reg;
    logic [hbt_pkg::KEY_W-1:0]      prod_reg;
    logic [BW-1:0]                  bucket_reg;
    logic [HANDLE_BITS-1:0]         nhdl_reg, nhdl_next;
    logic                           ovalid_reg, ovalid_next;
    logic [hbt_pkg::STAT_W-1:0]     ostat_reg;
    logic [hbt_pkg::M_DATA_W-1:0]   odata_reg;

    logic                           ram_we, ram_re;
    logic [BW-1:0]                  ram_waddr, ram_raddr;
    logic [ROW_W-1:0]               ram_wdata, row;

    logic [hbt_pkg::KEY_W-1:0]      fold;
    logic                           accept, eval_go;

    // Evaluation results
    logic                           hit, has_empty, refuse, is_ins, do_write;
    logic [hbt_pkg::WAY_W-1:0]      hit_way, empty_way, best_way, sel_way;
    logic [PRIO_BITS-1:0]           rp;
    logic [HANDLE_BITS-1:0]         new_hdl, res_hdl;
    logic [hbt_pkg::STAT_W-1:0]     res_stat;
    logic [hbt_pkg::WAY_W-1:0]      res_way;
    logic [ROW_W-1:0]               new_row;

    assign accept  = s_tvalid && s_tready;
    assign eval_go = (state_reg == hbt_pkg::S_EVAL) && (!ovalid_reg || m_tready);
    assign fold    = prod_reg ^ (prod_reg >> 16);

    assign s_tready = (state_reg == hbt_pkg::S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ostat_reg;

    hbt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (row)
    );

    assign ram_re    = (state_reg == hbt_pkg::S_ADDR);
    assign ram_raddr = fold[BW-1:0];
    assign ram_we    = (state_reg == hbt_pkg::S_CLEAR) || (eval_go && do_write);
    assign ram_waddr = (state_reg == hbt_pkg::S_CLEAR) ? clr_reg : bucket_reg;
    assign ram_wdata = (state_reg == hbt_pkg::S_CLEAR) ? '0 : new_row;

    // Row evaluation: hit search, free way search and victim choice.
    always_comb
    begin
        logic [hbt_pkg::KEY_W-1:0] k;
        logic [AGE_BITS-1:0]       age_gap;
        logic [RANK_W-1:0]         rank, best_rank;
        logic [EW-1:0]             ent;
        hit       = 1'b0;
        has_empty = 1'b0;
        hit_way   = '0;
        empty_way = '0;
        best_way  = '0;
        best_rank = '0;
        ent       = '0;
        for (int w = hbt_pkg::WAYS - 1; w >= 0; w--)
        begin
            k = row[w*EW +: hbt_pkg::KEY_W];
            if (k == addr_reg)
            begin
                hit     = 1'b1;
                hit_way = hbt_pkg::WAY_W'(w);
            end
            if (k == '0)
            begin
                has_empty = 1'b1;
                empty_way = hbt_pkg::WAY_W'(w);
            end
        end
        for (int w = 0; w < hbt_pkg::WAYS; w++)
        begin
            age_gap = now_reg - row[w*EW + AGE_LO +: AGE_BITS];
            rank = {row[w*EW + PRIO_LO +: PRIO_BITS], ~age_gap};
            if (w == 0 || rank < best_rank)
            begin
                best_rank = rank;
                best_way  = hbt_pkg::WAY_W'(w);
            end
        end

        is_ins = (op_reg == hbt_pkg::OP_INSERT) || (op_reg == hbt_pkg::OP_INSERT_AUTH);
        rp     = (op_reg == hbt_pkg::OP_INSERT_AUTH) ? preq_reg : '0;
        sel_way = has_empty ? empty_way : best_way;
        refuse = !has_empty && (row[best_way*EW + PRIO_LO +: PRIO_BITS] > rp);

        new_hdl = nhdl_reg + 1'b1;
        if (new_hdl == '0)
        begin
            new_hdl = HANDLE_BITS'(1);
        end

        new_row   = row;
        do_write  = 1'b0;
        nhdl_next = nhdl_reg;
        res_stat  = hbt_pkg::ST_MISSING;
        res_way   = '0;
        res_hdl   = '0;
        if (addr_reg == '0)
        begin
            res_stat = is_ins ? hbt_pkg::ST_REFUSED : hbt_pkg::ST_MISSING;
        end
        else if (hit)
        begin
            res_stat = hbt_pkg::ST_FOUND;
            res_way  = hit_way;
            res_hdl  = row[hit_way*EW + HDL_LO +: HANDLE_BITS];
            if (op_reg == hbt_pkg::OP_INSERT_AUTH &&
                row[hit_way*EW + PRIO_LO +: PRIO_BITS] < preq_reg)
            begin
                new_row[hit_way*EW + PRIO_LO +: PRIO_BITS] = preq_reg;
                do_write = 1'b1;
            end
        end
        else if (is_ins)
        begin
            if (refuse)
            begin
                res_stat = hbt_pkg::ST_REFUSED;
            end
            else
            begin
                res_stat = hbt_pkg::ST_INSERTED;
                res_way  = sel_way;
                if (op_reg == hbt_pkg::OP_INSERT)
                begin
                    res_hdl   = new_hdl;
                    nhdl_next = new_hdl;
                end
                ent = {res_hdl, rp, now_reg, addr_reg};
                new_row[sel_way*EW +: EW] = ent;
                do_write = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            hbt_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = hbt_pkg::S_IDLE;
                end
            end
            hbt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = hbt_pkg::S_MULT;
                end
            end
            hbt_pkg::S_MULT:
            begin
                state_next = hbt_pkg::S_ADDR;
            end
            hbt_pkg::S_ADDR:
            begin
                state_next = hbt_pkg::S_EVAL;
            end
            hbt_pkg::S_EVAL:
            begin
                if (eval_go)
                begin
                    ovalid_next = 1'b1;
                    state_next  = hbt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hbt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hbt_pkg::S_CLEAR;
            clr_reg    <= '0;
            nhdl_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            if (eval_go)
            begin
                nhdl_reg <= nhdl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser;
            addr_reg <= s_tdata[31:0];
            preq_reg <= PRIO_BITS'(s_tdata[35:32]);
            now_reg  <= AGE_BITS'(s_tdata[47:36]);
        end
        if (state_reg == hbt_pkg::S_MULT)
        begin
            prod_reg <= addr_reg * hbt_pkg::HASH_MUL;
        end
        if (state_reg == hbt_pkg::S_ADDR)
        begin
            bucket_reg <= fold[BW-1:0];
        end
        if (eval_go)
        begin
            ostat_reg <= res_stat;
            odata_reg <= {7'd0, hbt_pkg::OHDL_W'(res_hdl),
                          hbt_pkg::OBKT_W'(bucket_reg), res_way};
        end
    end

    // A finished evaluation always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        eval_go |=> m_tvalid)
        else $error("result lost after evaluation");

    // The row RAM is only written during the sweep or at an evaluation.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == hbt_pkg::S_CLEAR || state_reg == hbt_pkg::S_EVAL))
        else $error("row write outside sweep or evaluation");

    // An ordinary insert never hands out the reserved handle zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (eval_go && op_reg == hbt_pkg::OP_INSERT && res_stat == hbt_pkg::ST_INSERTED)
            |=> (m_tdata[32:13] != '0 || HANDLE_BITS > hbt_pkg::OHDL_W))
        else $error("reserved handle issued");

endmodule

// File: verif/tb_host_bucket_table_core.sv
// Testbench for the host bucket table: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module tb_host_bucket_table_core;

    localparam int NBKT = 1024;

    typedef struct packed {
        hbt_pkg::opcode_t op;
        logic [31:0]      addr;
        logic [3:0]       prio;
        logic [11:0]      now;
    } req_t;

    typedef struct packed {
        hbt_pkg::status_t status;
        logic [2:0]       way;
        logic [9:0]       bucket;
        logic [19:0]      handle;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [hbt_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [hbt_pkg::OPC_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [hbt_pkg::M_DATA_W-1:0] m_tdata;
    logic [hbt_pkg::STAT_W-1:0] m_tuser;

    host_bucket_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // Predictor state.
    logic [31:0] tbl_key [NBKT*8];
    logic [11:0] tbl_age [NBKT*8];
    logic [3:0]  tbl_prio [NBKT*8];
    logic [19:0] tbl_hdl [NBKT*8];
    bit          tbl_full [NBKT];
    logic [19:0] hdl_ctr;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    errors = 0;
    int    sent = 0;
    int    received = 0;
    bit    calm = 1'b0;
    int    n_ins = 0;
    int    n_evict = 0;
    int    n_refused = 0;
    logic [31:0] used_addrs[$];

    // Acceptance as seen at the last rising edge.
    logic s_tready_q = 1'b0;

    function automatic logic [9:0] hash_bucket(logic [31:0] a);
        logic [31:0] h;
        h = a * hbt_pkg::HASH_MUL;
        h = h ^ (h >> 16);
        return h[9:0];
    endfunction

    function automatic resp_t table_access(req_t r);
        resp_t res;
        int base;
        int hit;
        int pick;
        logic [3:0] rp;
        logic [15:0] k;
        logic [15:0] best_k;
        logic [11:0] age_gap;
        res.status = hbt_pkg::ST_MISSING;
        res.way = '0;
        res.handle = '0;
        res.bucket = hash_bucket(r.addr);
        base = res.bucket * 8;
        hit = -1;
        pick = -1;
        if (r.addr == 0)
        begin
            if (r.op == hbt_pkg::OP_INSERT || r.op == hbt_pkg::OP_INSERT_AUTH)
                res.status = hbt_pkg::ST_REFUSED;
            return res;
        end
        for (int w = 0; w < 8; w++)
            if (hit < 0 && tbl_key[base+w] == r.addr)
                hit = w;
        if (hit >= 0)
        begin
            res.status = hbt_pkg::ST_FOUND;
            res.way = hit[2:0];
            res.handle = tbl_hdl[base+hit];
            if (r.op == hbt_pkg::OP_INSERT_AUTH && tbl_prio[base+hit] < r.prio)
                tbl_prio[base+hit] = r.prio;
            return res;
        end
        if (r.op != hbt_pkg::OP_INSERT && r.op != hbt_pkg::OP_INSERT_AUTH)
            return res;
        rp = (r.op == hbt_pkg::OP_INSERT_AUTH) ? r.prio : 4'd0;
        if (!tbl_full[res.bucket])
        begin
            for (int w = 0; w < 8; w++)
                if (pick < 0 && tbl_key[base+w] == 0)
                    pick = w;
            if (pick < 0 || pick == 7)
                tbl_full[res.bucket] = 1'b1;
        end
        if (pick < 0)
        begin
            // Lowest priority first, then the oldest entry, then the lowest way.
            best_k = '1;
            for (int w = 0; w < 8; w++)
            begin
                age_gap = r.now - tbl_age[base+w];
                k = {tbl_prio[base+w], ~age_gap};
                if (w == 0 || k < best_k)
                begin
                    best_k = k;
                    pick = w;
                end
            end
            if (tbl_prio[base+pick] > rp)
            begin
                res.status = hbt_pkg::ST_REFUSED;
                n_refused++;
                return res;
            end
            n_evict++;
        end
        tbl_key[base+pick] = r.addr;
        tbl_age[base+pick] = r.now;
        tbl_prio[base+pick] = rp;
        if (r.op == hbt_pkg::OP_INSERT)
        begin
            hdl_ctr = hdl_ctr + 20'd1;
            if (hdl_ctr == 0)
                hdl_ctr = 20'd1;
            res.handle = hdl_ctr;
        end
        tbl_hdl[base+pick] = res.handle;
        res.status = hbt_pkg::ST_INSERTED;
        res.way = pick[2:0];
        n_ins++;
        return res;
    endfunction

    // Addresses that land in a chosen bucket, used to fill and overflow buckets.
    function automatic logic [31:0] addr_in_bucket(logic [9:0] b);
        logic [31:0] a;
        do
            a = $urandom;
        while (a == 0 || hash_bucket(a) != b);
        return a;
    endfunction

    function automatic req_t mk(hbt_pkg::opcode_t op, logic [31:0] a, logic [3:0] p,
                                logic [11:0] t);
        req_t r;
        r.op = op;
        r.addr = a;
        r.prio = p;
        r.now = t;
        return r;
    endfunction

    function automatic hbt_pkg::opcode_t rand_op();
        int v;
        v = $urandom_range(0, 99);
        if (v < 30)
            return hbt_pkg::OP_LOOKUP;
        if (v < 60)
            return hbt_pkg::OP_INSERT;
        if (v < 95)
            return hbt_pkg::OP_INSERT_AUTH;
        return hbt_pkg::OP_UNUSED;
    endfunction

    always @(posedge clk)
        s_tready_q <= s_tready;

    // Driver.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready_q)
            begin
                sent <= sent + 1;
            end
            if (!s_tvalid || s_tready_q)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 26))
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.op;
                    s_tdata <= {r.now, r.prio, r.addr};
                    expected_resps.push_back(table_access(r));
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            resp_t exp_r;
            received <= received + 1;
            if (expected_resps.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d tdata=%h", $time, m_tuser, m_tdata);
                errors <= errors + 1;
            end
            else
            begin
                exp_r = expected_resps.pop_front();
                if (m_tuser !== exp_r.status || m_tdata[2:0] !== exp_r.way ||
                    m_tdata[12:3] !== exp_r.bucket || m_tdata[32:13] !== exp_r.handle ||
                    m_tdata[39:33] !== 7'd0)
                begin
                    $display("%0t: mismatch expected st=%0d way=%0d bkt=%0d hdl=%0d",
                             $time, exp_r.status, exp_r.way, exp_r.bucket, exp_r.handle);
                    $display("%0t:          actual   st=%0d way=%0d bkt=%0d hdl=%0d pad=%h",
                             $time, m_tuser, m_tdata[2:0], m_tdata[12:3], m_tdata[32:13],
                             m_tdata[39:33]);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", expected_resps.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [9:0] hot;
        logic [31:0] a;
        logic [11:0] clock_s;
        int drain;
        for (int i = 0; i < NBKT*8; i++)
        begin
            tbl_key[i] = '0;
            tbl_age[i] = '0;
            tbl_prio[i] = '0;
            tbl_hdl[i] = '0;
        end
        for (int i = 0; i < NBKT; i++)
            tbl_full[i] = 1'b0;
        hdl_ctr = '0;

        // Directed: zero address, extremes, unused opcode, fill and overflow one bucket.
        pending_reqs.push_back(mk(hbt_pkg::OP_LOOKUP, 32'd0, 4'd0, 12'd0));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT, 32'd0, 4'd15, 12'hFFF));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT_AUTH, 32'd0, 4'd15, 12'hFFF));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT_AUTH, 32'hFFFF_FFFF, 4'd15, 12'hFFF));
        pending_reqs.push_back(mk(hbt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 4'd0, 12'd0));
        pending_reqs.push_back(mk(hbt_pkg::OP_UNUSED, 32'hFFFF_FFFF, 4'd0, 12'd0));
        pending_reqs.push_back(mk(hbt_pkg::OP_UNUSED, 32'h1234_5678, 4'd0, 12'd0));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT, 32'h0000_0001, 4'd0, 12'd0));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT, 32'h0000_0001, 4'd0, 12'd5));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT_AUTH, 32'h0000_0001, 4'd9, 12'd5));
        hot = 10'd0;
        for (int i = 0; i < 8; i++)
            pending_reqs.push_back(mk(i % 2 ? hbt_pkg::OP_INSERT : hbt_pkg::OP_INSERT_AUTH,
                                      addr_in_bucket(hot), 4'(i % 3), 12'(100 + i)));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT, addr_in_bucket(hot), 4'd0, 12'd3));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT_AUTH, addr_in_bucket(hot), 4'd15, 12'd0));
        pending_reqs.push_back(mk(hbt_pkg::OP_INSERT, addr_in_bucket(hot), 4'd0, 12'd4095));

        // Random: mostly traffic aimed at a few hot buckets so they fill and evict.
        clock_s = $urandom;
        for (int i = 0; i < 950; i++)
        begin
            clock_s = clock_s + 12'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 70)
            begin
                hot = 10'($urandom_range(0, 15));
                if (used_addrs.size() != 0 && $urandom_range(0, 2) == 0)
                    a = used_addrs[$urandom_range(0, used_addrs.size() - 1)];
                else
                begin
                    a = addr_in_bucket(hot);
                    used_addrs.push_back(a);
                end
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                a = 32'd0;
            end
            else
            begin
                a = $urandom;
            end
            pending_reqs.push_back(mk(rand_op(), a, 4'($urandom), $urandom_range(0, 9) == 0 ?
                                      12'($urandom) : clock_s));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            begin
                wait (pending_reqs.size() < 400);
                calm = 1'b1;
                wait (pending_reqs.size() < 250);
                calm = 1'b0;
            end
        join_none
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_resps.size() == 0);
        drain = 0;
        while (drain < 50)
        begin
            @(posedge clk);
            drain++;
        end
        $display("Covered %0d requests sent and %0d results checked under random stalls.",
                 sent, received);
        $display("The predictor saw %0d inserts, %0d evictions and %0d refusals.",
                 n_ins, n_evict, n_refused);
        if (errors == 0 && expected_resps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
